### hdl/srp_pkg.sv
// Shared types and constants for the stepper ramp profile block.
`timescale 1ns / 1ps
`default_nettype none

package srp_pkg;

   // Request kinds carried in req_tuser.
   localparam logic [1:0] OP_TARGET = 2'd0;
   localparam logic [1:0] OP_PULSE  = 2'd1;
   localparam logic [1:0] OP_HOME   = 2'd2;

   // Configuration register indexes.
   localparam logic [2:0] CSR_ACCEL_RATE   = 3'd0;
   localparam logic [2:0] CSR_MAX_VELOCITY = 3'd1;
   localparam logic [2:0] CSR_MIN_VELOCITY = 3'd2;
   localparam logic [2:0] CSR_RAMP_PULSES  = 3'd3;
   localparam logic [2:0] CSR_SLOW_PERIOD  = 3'd4;
   localparam logic [2:0] CSR_START_PERIOD = 3'd5;

   // Reset values of the configuration registers and of the period.
   localparam logic [7:0]  ACCEL_RATE_RESET   = 8'd20;
   localparam logic [11:0] MAX_VELOCITY_RESET = 12'd500;
   localparam logic [11:0] MIN_VELOCITY_RESET = 12'd20;
   localparam logic [15:0] RAMP_PULSES_RESET  = 16'd1000;
   localparam logic [15:0] SLOW_PERIOD_RESET  = 16'd50;
   localparam logic [15:0] START_PERIOD_RESET = 16'd15000;

   // Period numerator is 10 * max_velocity in Q.8.
   localparam logic [11:0] PERIOD_SCALE = 12'd2560;

   // Iteration counts of the shared unit.
   localparam int ROOT_STEPS = 21;
   localparam int DIV_STEPS  = 24;

   typedef enum logic [1:0] {
      CTL_IDLE,
      CTL_CALC,
      CTL_EMIT
   } ctl_state_type;

   typedef enum logic [2:0] {
      UNIT_IDLE,
      UNIT_MUL,
      UNIT_ROOT,
      UNIT_CLAMP,
      UNIT_DIV,
      UNIT_DONE
   } unit_state_type;

   typedef struct packed {
      logic [7:0]  accel_rate;
      logic [11:0] max_velocity;
      logic [11:0] min_velocity;
   } unit_cfg_type;

   typedef struct packed {
      logic        start;
      logic        accel;
      logic [15:0] n;
   } unit_cmd_type;

   typedef struct packed {
      logic        done;
      logic [15:0] period;
   } unit_res_type;

endpackage

`default_nettype wire

### hdl/srp_period_unit.sv
// Iterative square root and divide unit that turns a pulse count into a step period.
`timescale 1ns / 1ps
`default_nettype none

module srp_period_unit (
   input  wire                   clock,
   input  wire                   reset,
   input  srp_pkg::unit_cfg_type cfg,
   input  srp_pkg::unit_cmd_type cmd,
   output srp_pkg::unit_res_type res
);

   srp_pkg::unit_state_type state_ff, state_in;
   logic [41:0] x_ff, x_in;
   logic [24:0] rem_ff, rem_in;
   logic [23:0] q_ff, q_in;
   logic [20:0] div_ff, div_in;
   logic [4:0]  cnt_ff, cnt_in;
   logic [15:0] n_ff, n_in;
   logic        accel_ff, accel_in;

   logic        root_mode;
   logic [24:0] shifted;
   logic [24:0] trial;
   logic [25:0] diff;
   logic        ge;
   logic [23:0] product;
   logic [23:0] numer;
   logic [20:0] vel;
   logic [20:0] vel_lo;
   logic [20:0] vel_hi;

   // One subtractor serves both the root digits and the quotient bits.
   always_comb begin
      root_mode = (state_ff == srp_pkg::UNIT_ROOT);
      if (root_mode) begin
         shifted = {rem_ff[22:0], x_ff[41:40]};
         trial   = {q_ff[22:0], 2'b01};
      end else begin
         shifted = {rem_ff[23:0], x_ff[41]};
         trial   = {4'b0, div_ff};
      end
      diff = {1'b0, shifted} - {1'b0, trial};
      ge   = ~diff[25];
   end

   always_comb begin
      product = 24'(cfg.accel_rate) * 24'(n_ff);
      numer   = 24'(cfg.max_velocity) * 24'(srp_pkg::PERIOD_SCALE);
      vel_lo  = {1'b0, cfg.min_velocity, 8'b0};
      vel_hi  = {1'b0, cfg.max_velocity, 8'b0};
      vel     = q_ff[20:0];
      if (vel < vel_lo) begin
         vel = vel_lo;
      end
      if (accel_ff && (vel > vel_hi)) begin
         vel = vel_hi;
      end
      if (vel == 21'd0) begin
         vel = 21'd1;
      end
   end

   always_comb begin
      state_in   = state_ff;
      x_in       = x_ff;
      rem_in     = rem_ff;
      q_in       = q_ff;
      div_in     = div_ff;
      cnt_in     = cnt_ff;
      n_in       = n_ff;
      accel_in   = accel_ff;
      res.done   = 1'b0;
      res.period = (q_ff[23:16] != 8'd0) ? 16'hFFFF : q_ff[15:0];
      case (state_ff)
         srp_pkg::UNIT_IDLE: begin
            if (cmd.start) begin
               n_in     = cmd.n;
               accel_in = cmd.accel;
               state_in = srp_pkg::UNIT_MUL;
            end
         end
         srp_pkg::UNIT_MUL: begin
            x_in     = {1'b0, product, 17'b0};
            rem_in   = '0;
            q_in     = '0;
            cnt_in   = '0;
            state_in = srp_pkg::UNIT_ROOT;
         end
         srp_pkg::UNIT_ROOT: begin
            x_in   = {x_ff[39:0], 2'b00};
            rem_in = ge ? diff[24:0] : shifted;
            q_in   = {q_ff[22:0], ge};
            cnt_in = cnt_ff + 5'd1;
            if (cnt_ff == 5'(srp_pkg::ROOT_STEPS - 1)) begin
               state_in = srp_pkg::UNIT_CLAMP;
            end
         end
         srp_pkg::UNIT_CLAMP: begin
            div_in   = vel;
            x_in     = {numer, 18'b0};
            rem_in   = '0;
            q_in     = '0;
            cnt_in   = '0;
            state_in = srp_pkg::UNIT_DIV;
         end
         srp_pkg::UNIT_DIV: begin
            x_in   = {x_ff[40:0], 1'b0};
            rem_in = ge ? diff[24:0] : shifted;
            q_in   = {q_ff[22:0], ge};
            cnt_in = cnt_ff + 5'd1;
            if (cnt_ff == 5'(srp_pkg::DIV_STEPS - 1)) begin
               state_in = srp_pkg::UNIT_DONE;
            end
         end
         srp_pkg::UNIT_DONE: begin
            res.done = 1'b1;
            state_in = srp_pkg::UNIT_IDLE;
         end
         default: begin
            state_in = srp_pkg::UNIT_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= srp_pkg::UNIT_IDLE;
      end else begin
         state_ff <= state_in;
      end
      x_ff     <= x_in;
      rem_ff   <= rem_in;
      q_ff     <= q_in;
      div_ff   <= div_in;
      cnt_ff   <= cnt_in;
      n_ff     <= n_in;
      accel_ff <= accel_in;
   end

endmodule

`default_nettype wire

### hdl/stepper_ramp_profile_core.sv
// Top level of the stepper ramp profile: event handling, move state and result register.
`timescale 1ns / 1ps
`default_nettype none

// Every request except a pulse on a ramp of a long move goes from IDLE straight to EMIT,
// which loads the response register; the next request is taken once the block is in IDLE.
// A ramp pulse request first waits in CALC while a 21-step square root and a 24-step divide
// run one after the other through the single subtractor of the period unit, between its start,
// load, clamp and finish steps. A stalled response holds the block until it leaves.
// Synchronous reset loads the configuration defaults, zeroes all positions and counts,
// sets the period to the slow period default and empties the response register.

module stepper_ramp_profile_core #(
   parameter int POS_BITS = 20
) (
   input  wire         clock,
   input  wire         reset,
   // Request channel.
   input  wire         req_tvalid,
   output logic        req_tready,
   input  wire  [23:0] req_tdata,  // [19:0] target_position, [23:20] zero
   input  wire  [1:0]  req_tuser,  // [1:0] operation
   // Response channel.
   output logic        rsp_tvalid,
   input  wire         rsp_tready,
   output logic [39:0] rsp_tdata,  // [15:0] step_period, [16] reverse, [17] drive_on,
                                   // [37:18] position, [38] busy_res, [39] move_done
   // Configuration write channel.
   input  wire         csr_valid,
   output logic        csr_ready,
   input  wire  [2:0]  csr_index,
   input  wire  [15:0] csr_data
);

   // Width that holds any position, count or doubled ramp length without overflow.
   localparam int CW = ((POS_BITS > 17) ? POS_BITS : 17) + 1;

   // Configuration registers.
   logic [7:0]  accel_ff, accel_in;
   logic [11:0] vmax_ff, vmax_in;
   logic [11:0] vmin_ff, vmin_in;
   logic [15:0] ramp_ff, ramp_in;
   logic [15:0] slow_ff, slow_in;
   logic [15:0] startp_ff, startp_in;

   // Move state.
   srp_pkg::ctl_state_type state_ff, state_in;
   logic [POS_BITS-1:0] cur_pos_ff, cur_pos_in;
   logic [POS_BITS-1:0] start_pos_ff, start_pos_in;
   logic [POS_BITS-1:0] dist_ff, dist_in;
   logic [POS_BITS-1:0] pulse_ff, pulse_in;
   logic [POS_BITS-1:0] last_tgt_ff, last_tgt_in;
   logic dir_ff, dir_in;
   logic run_ff, run_in;
   logic long_ff, long_in;
   logic drive_ff, drive_in;
   logic done_ff, done_in;
   logic [15:0] period_ff, period_in;

   // Response register.
   logic        rsp_valid_ff, rsp_valid_in;
   logic [39:0] rsp_data_ff, rsp_data_in;

   // Request decode.
   logic [POS_BITS-1:0] tgt;
   logic [POS_BITS-1:0] dist_new;
   logic [POS_BITS-1:0] pc_inc;
   logic [POS_BITS-1:0] pos_step;
   logic [POS_BITS-1:0] n_wide;
   logic                tgt_below;
   logic                long_new;
   logic                accel_hit;
   logic                decel_hit;

   srp_pkg::unit_cfg_type unit_cfg;
   srp_pkg::unit_cmd_type unit_cmd;
   srp_pkg::unit_res_type unit_res;

   srp_period_unit u_period (
      .clock (clock),
      .reset (reset),
      .cfg   (unit_cfg),
      .cmd   (unit_cmd),
      .res   (unit_res)
   );

   assign unit_cfg.accel_rate   = accel_ff;
   assign unit_cfg.max_velocity = vmax_ff;
   assign unit_cfg.min_velocity = vmin_ff;

   // Configuration writes are taken whenever reset is low; unknown indexes fall through unused.
   always_comb begin
      csr_ready = ~reset;
      accel_in  = accel_ff;
      vmax_in   = vmax_ff;
      vmin_in   = vmin_ff;
      ramp_in   = ramp_ff;
      slow_in   = slow_ff;
      startp_in = startp_ff;
      if (csr_valid && csr_ready) begin
         case (csr_index)
            srp_pkg::CSR_ACCEL_RATE:   accel_in  = csr_data[7:0];
            srp_pkg::CSR_MAX_VELOCITY: vmax_in   = csr_data[11:0];
            srp_pkg::CSR_MIN_VELOCITY: vmin_in   = csr_data[11:0];
            srp_pkg::CSR_RAMP_PULSES:  ramp_in   = csr_data;
            srp_pkg::CSR_SLOW_PERIOD:  slow_in   = csr_data;
            srp_pkg::CSR_START_PERIOD: startp_in = csr_data;
            default: begin
            end
         endcase
      end
   end

   // Arithmetic needed to decide what a request does. The pulse count never
   // exceeds the move distance, and a long move is longer than two ramps, so
   // the deceleration test can be written as a sum instead of a difference.
   always_comb begin
      tgt       = POS_BITS'(req_tdata[19:0]);
      tgt_below = (tgt < cur_pos_ff);
      dist_new  = tgt_below ? (cur_pos_ff - tgt) : (tgt - cur_pos_ff);
      long_new  = (CW'(dist_new) > CW'({ramp_ff, 1'b0}));
      pc_inc    = pulse_ff + POS_BITS'(1);
      pos_step  = dir_ff ? (start_pos_ff - pc_inc) : (start_pos_ff + pc_inc);
      accel_hit = (CW'(pc_inc) < CW'(ramp_ff));
      decel_hit = ((CW'(pc_inc) + CW'(ramp_ff)) > CW'(dist_ff));
      n_wide    = accel_hit ? pc_inc : (dist_ff - pc_inc);
   end

   // Control sequencer: take a request, wait for the period unit if a ramp
   // step needs a new period, then hand the status to the response register.
   always_comb begin
      state_in       = state_ff;
      cur_pos_in     = cur_pos_ff;
      start_pos_in   = start_pos_ff;
      dist_in        = dist_ff;
      pulse_in       = pulse_ff;
      last_tgt_in    = last_tgt_ff;
      dir_in         = dir_ff;
      run_in         = run_ff;
      long_in        = long_ff;
      drive_in       = drive_ff;
      done_in        = done_ff;
      period_in      = period_ff;
      rsp_valid_in   = rsp_valid_ff;
      rsp_data_in    = rsp_data_ff;
      req_tready     = 1'b0;
      unit_cmd.start = 1'b0;
      unit_cmd.accel = accel_hit;
      unit_cmd.n     = 16'(n_wide);

      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         srp_pkg::CTL_IDLE: begin
            req_tready = ~reset;
            if (req_tvalid && req_tready) begin
               done_in  = 1'b0;
               state_in = srp_pkg::CTL_EMIT;
               case (req_tuser)
                  srp_pkg::OP_TARGET: begin
                     if (!run_ff && (tgt != last_tgt_ff)) begin
                        last_tgt_in  = tgt;
                        start_pos_in = cur_pos_ff;
                        dir_in       = tgt_below;
                        dist_in      = dist_new;
                        pulse_in     = '0;
                        drive_in     = 1'b1;
                        long_in      = long_new;
                        period_in    = long_new ? startp_ff : slow_ff;
                        if (dist_new == '0) begin
                           done_in = 1'b1;
                        end else begin
                           run_in = 1'b1;
                        end
                     end
                  end
                  srp_pkg::OP_PULSE: begin
                     if (run_ff) begin
                        pulse_in   = pc_inc;
                        cur_pos_in = pos_step;
                        if (pc_inc >= dist_ff) begin
                           run_in   = 1'b0;
                           drive_in = 1'b0;
                           done_in  = 1'b1;
                        end else if (long_ff && (accel_hit || decel_hit)) begin
                           unit_cmd.start = 1'b1;
                           state_in       = srp_pkg::CTL_CALC;
                        end
                     end
                  end
                  srp_pkg::OP_HOME: begin
                     done_in    = run_ff;
                     run_in     = 1'b0;
                     drive_in   = 1'b0;
                     pulse_in   = '0;
                     cur_pos_in = '0;
                  end
                  default: begin
                  end
               endcase
            end
         end
         srp_pkg::CTL_CALC: begin
            if (unit_res.done) begin
               period_in = unit_res.period;
               state_in  = srp_pkg::CTL_EMIT;
            end
         end
         srp_pkg::CTL_EMIT: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {done_ff, run_ff, 20'(cur_pos_ff), drive_ff, dir_ff, period_ff};
               state_in     = srp_pkg::CTL_IDLE;
            end
         end
         default: begin
            state_in = srp_pkg::CTL_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         accel_ff     <= srp_pkg::ACCEL_RATE_RESET;
         vmax_ff      <= srp_pkg::MAX_VELOCITY_RESET;
         vmin_ff      <= srp_pkg::MIN_VELOCITY_RESET;
         ramp_ff      <= srp_pkg::RAMP_PULSES_RESET;
         slow_ff      <= srp_pkg::SLOW_PERIOD_RESET;
         startp_ff    <= srp_pkg::START_PERIOD_RESET;
         state_ff     <= srp_pkg::CTL_IDLE;
         cur_pos_ff   <= '0;
         start_pos_ff <= '0;
         dist_ff      <= '0;
         pulse_ff     <= '0;
         last_tgt_ff  <= '0;
         dir_ff       <= 1'b0;
         run_ff       <= 1'b0;
         long_ff      <= 1'b0;
         drive_ff     <= 1'b0;
         done_ff      <= 1'b0;
         period_ff    <= srp_pkg::SLOW_PERIOD_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         accel_ff     <= accel_in;
         vmax_ff      <= vmax_in;
         vmin_ff      <= vmin_in;
         ramp_ff      <= ramp_in;
         slow_ff      <= slow_in;
         startp_ff    <= startp_in;
         state_ff     <= state_in;
         cur_pos_ff   <= cur_pos_in;
         start_pos_ff <= start_pos_in;
         dist_ff      <= dist_in;
         pulse_ff     <= pulse_in;
         last_tgt_ff  <= last_tgt_in;
         dir_ff       <= dir_in;
         run_ff       <= run_in;
         long_ff      <= long_in;
         drive_ff     <= drive_in;
         done_ff      <= done_in;
         period_ff    <= period_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

`default_nettype wire
